// ===== rtl/core/xpn_pkg.sv =====
// Package for the binarised neuron array: request codes, widths, the
// per-neuron command struct and the match_count function. It depends on nothing else.
`default_nettype none

package xpn_pkg;

    localparam int NEURON_COUNT = 8;
    localparam int IDX_W        = 3;
    localparam int WEIGHT_W     = 8;
    localparam int ACC_W        = 10;
    localparam int POP_W        = 4;

    localparam logic [ACC_W-1:0] ACC_MAX = {ACC_W{1'b1}};

    typedef enum logic [1:0] {
        REQ_CLEAR = 2'd0,
        REQ_LOAD  = 2'd1,
        REQ_BCAST = 2'd2,
        REQ_READ  = 2'd3
    } req_t;

    typedef struct packed {
        logic                clear;
        logic                bcast;
        logic [WEIGHT_W-1:0] data;
    } neuron_cmd_t;

    function automatic logic [POP_W-1:0] match_count(
        input logic [WEIGHT_W-1:0] w,
        input logic [WEIGHT_W-1:0] d
    );
        logic [WEIGHT_W-1:0] x;
        logic [POP_W-1:0]    n;
        x = ~(w ^ d);
        n = '0;
        for (int i = 0; i < WEIGHT_W; i++)
        begin
            n = n + POP_W'(x[i]);
        end
        return n;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/xpn_neuron.sv =====
// One binarised neuron: its weight byte, its saturating accumulator and the
// XNOR and popcount update. Depends on xpn_pkg.
`default_nettype none

module xpn_neuron
    import xpn_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire neuron_cmd_t         cmd,
    input  wire logic                load,
    output logic [ACC_W-1:0]         acc_next
);

    logic [WEIGHT_W-1:0] weight_reg;
    logic [WEIGHT_W-1:0] weight_next;
    logic [ACC_W-1:0]    acc_reg;
    logic [ACC_W:0]      sum;

    always_comb
    begin
        sum         = {1'b0, acc_reg} + (ACC_W + 1)'(match_count(weight_reg, cmd.data));
        weight_next = load ? cmd.data : weight_reg;
        if (cmd.clear)
        begin
            acc_next = '0;
        end
        else if (cmd.bcast)
        begin
            acc_next = sum[ACC_W] ? ACC_MAX : sum[ACC_W-1:0];
        end
        else
        begin
            acc_next = acc_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            weight_reg <= '0;
            acc_reg    <= '0;
        end
        else
        begin
            weight_reg <= weight_next;
            acc_reg    <= acc_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/xnor_popcount_neuron_array.sv =====
// Top level of the binarised neuron array: input register, the neuron row
// and the result register. Depends on xpn_pkg and xpn_neuron.
//
// Each item is one access (clear, load weight, broadcast, read) and yields
// one item carrying the addressed neuron's accumulator after the access.
// One item is taken per cycle while the input is not stalled; an accepted
// item passes through the input register and then the result register, and
// the state of all neurons is updated as the item moves from the first to
// the second. The input is stalled only when both registers hold items and
// the output is stalled.
`default_nettype none

module xnor_popcount_neuron_array
    import xpn_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire logic [1:0]         req_type,
    input  wire logic [IDX_W-1:0]   neuron_index,
    input  wire logic [WEIGHT_W-1:0] data_byte,
    output logic                    out_valid,
    input  wire logic               out_stall,
    output logic [ACC_W-1:0]        acc_value
);

    logic                 s1_valid_reg;
    logic [1:0]           s1_req_reg;
    logic [IDX_W-1:0]     s1_idx_reg;
    logic [WEIGHT_W-1:0]  s1_data_reg;
    logic                 out_valid_reg;
    logic [ACC_W-1:0]     acc_value_reg;
    logic                 s1_move;
    logic                 in_take;
    logic                 idx_ok;
    neuron_cmd_t          cmd;
    logic                 load_any;
    logic [NEURON_COUNT-1:0]   load_sel;
    logic [ACC_W-1:0]     acc_next [NEURON_COUNT];
    logic [ACC_W-1:0]     result_next;

    assign s1_move  = s1_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall = s1_valid_reg && !s1_move;
    assign in_take  = in_valid && !in_stall;
    assign idx_ok   = 32'(s1_idx_reg) < NEURON_COUNT;

    always_comb
    begin
        cmd.clear = 1'b0;
        cmd.bcast = 1'b0;
        cmd.data  = s1_data_reg;
        load_any  = 1'b0;
        unique case (req_t'(s1_req_reg))
            REQ_CLEAR: cmd.clear = s1_move;
            REQ_LOAD:  load_any  = s1_move && idx_ok;
            REQ_BCAST: cmd.bcast = s1_move;
            REQ_READ:  ;
            default:   ;
        endcase
    end

    genvar g;
    generate
        for (g = 0; g < NEURON_COUNT; g++)
        begin : g_neuron
            assign load_sel[g] = load_any && (32'(s1_idx_reg) == g);

            xpn_neuron u_neuron (
                .clk      (clk),
                .rst_n    (rst_n),
                .cmd      (cmd),
                .load     (load_sel[g]),
                .acc_next (acc_next[g])
            );
        end
    endgenerate

    always_comb
    begin
        result_next = '0;
        for (int i = 0; i < NEURON_COUNT; i++)
        begin
            if (32'(s1_idx_reg) == i)
            begin
                result_next = acc_next[i];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_take)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_move)
            begin
                s1_valid_reg <= 1'b0;
            end
            if (s1_move)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            s1_req_reg  <= req_type;
            s1_idx_reg  <= neuron_index;
            s1_data_reg <= data_byte;
        end
        if (s1_move)
        begin
            acc_value_reg <= result_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign acc_value = acc_value_reg;

endmodule

`default_nettype wire

// ===== dv/tb_xnor_popcount_neuron_array.sv =====
// Self-checking testbench for xnor_popcount_neuron_array. It runs directed and random
// accesses against an internal predictor, with random gaps on the input and stalls on
// the output. It depends on xpn_pkg and the RTL of the block.
`timescale 1ns / 1ps

module tb_xnor_popcount_neuron_array;
    import xpn_pkg::*;

    typedef struct {
        req_t                req;
        logic [IDX_W-1:0]    idx;
        logic [WEIGHT_W-1:0] data;
    } access_t;

    logic                clk          = 1'b0;
    logic                rst_n        = 1'b0;
    logic                in_valid     = 1'b0;
    logic                in_stall;
    logic [1:0]          req_type     = '0;
    logic [IDX_W-1:0]    neuron_index = '0;
    logic [WEIGHT_W-1:0] data_byte    = '0;
    logic                out_valid;
    logic                out_stall    = 1'b0;
    logic [ACC_W-1:0]    acc_value;

    access_t             pending_accesses[$];
    logic [ACC_W-1:0]    expected_acc_values[$];
    logic [WEIGHT_W-1:0] weight_shadow[NEURON_COUNT];
    logic [ACC_W-1:0]    acc_shadow[NEURON_COUNT];
    int                  error_count = 0;
    int                  stimulus_count = 0;
    int                  in_gap = 0;
    int                  in_calm = 0;
    int                  out_wait = 0;
    int                  out_calm = 0;

    xnor_popcount_neuron_array i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .req_type     (req_type),
        .neuron_index (neuron_index),
        .data_byte    (data_byte),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .acc_value    (acc_value)
    );

    initial
    begin
        forever #4 clk = ~clk;
    end

    function automatic logic [ACC_W-1:0] predict_access(
        input req_t                req,
        input logic [IDX_W-1:0]    idx,
        input logic [WEIGHT_W-1:0] data
    );
        int sum;
        case (req)
            REQ_CLEAR:
            begin
                for (int n = 0; n < NEURON_COUNT; n++)
                begin
                    acc_shadow[n] = '0;
                end
            end
            REQ_LOAD:
            begin
                if (int'(idx) < NEURON_COUNT)
                begin
                    weight_shadow[idx] = data;
                end
            end
            REQ_BCAST:
            begin
                for (int n = 0; n < NEURON_COUNT; n++)
                begin
                    sum = int'(acc_shadow[n]) + $countones(~(weight_shadow[n] ^ data));
                    acc_shadow[n] = (sum > int'(ACC_MAX)) ? ACC_MAX : ACC_W'(sum);
                end
            end
            default:
            begin
            end
        endcase
        if (int'(idx) >= NEURON_COUNT)
        begin
            return '0;
        end
        return acc_shadow[idx];
    endfunction

    // Mostly short gaps, a few long ones, and now and then a stretch with none at all.
    function automatic int next_gap(inout int calm);
        int r;
        r = $urandom_range(0, 99);
        if (calm > 0)
        begin
            calm = calm - 1;
            return 0;
        end
        if (r < 3)
        begin
            calm = $urandom_range(20, 60);
            return 0;
        end
        if (r < 55)
        begin
            return 0;
        end
        if (r < 92)
        begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    task automatic add_access(input req_t req, input int idx, input int data);
        access_t a;
        a.req  = req;
        a.idx  = IDX_W'(idx);
        a.data = WEIGHT_W'(data);
        pending_accesses.push_back(a);
        stimulus_count++;
    endtask

    function automatic req_t random_req();
        int r;
        r = $urandom_range(0, 99);
        if (r < 5)
        begin
            return REQ_CLEAR;
        end
        if (r < 30)
        begin
            return REQ_LOAD;
        end
        if (r < 70)
        begin
            return REQ_BCAST;
        end
        return REQ_READ;
    endfunction

    // Long broadcast runs drive the accumulators into saturation, most of them
    // matching one neuron's weight exactly so that it gains eight per broadcast.
    task automatic add_saturation_run();
        logic [WEIGHT_W-1:0] w[NEURON_COUNT];
        int                  target;
        int                  runs;
        for (int n = 0; n < NEURON_COUNT; n++)
        begin
            w[n] = WEIGHT_W'($urandom_range(0, 255));
            add_access(REQ_LOAD, n, w[n]);
        end
        target = $urandom_range(0, NEURON_COUNT - 1);
        runs   = $urandom_range(140, 200);
        repeat (runs)
        begin
            if ($urandom_range(0, 3) == 0)
            begin
                add_access(REQ_BCAST, $urandom_range(0, 7), $urandom_range(0, 255));
            end
            else
            begin
                add_access(REQ_BCAST, $urandom_range(0, 7), w[target]);
            end
            if ($urandom_range(0, 4) == 0)
            begin
                add_access(REQ_READ, $urandom_range(0, 7), $urandom_range(0, 255));
            end
        end
        add_access(REQ_CLEAR, $urandom_range(0, 7), $urandom_range(0, 255));
    endtask

    always @(posedge clk or negedge rst_n)
    begin : drive_accesses
        access_t next_access;
        if (!rst_n)
        begin
            in_valid     <= 1'b0;
            req_type     <= '0;
            neuron_index <= '0;
            data_byte    <= '0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                expected_acc_values.push_back(
                    predict_access(req_t'(req_type), neuron_index, data_byte));
            end
            if (!in_valid || !in_stall)
            begin
                if (in_gap > 0 || pending_accesses.size() == 0)
                begin
                    in_valid <= 1'b0;
                    if (in_gap > 0)
                    begin
                        in_gap <= in_gap - 1;
                    end
                end
                else
                begin
                    next_access   = pending_accesses.pop_front();
                    in_valid     <= 1'b1;
                    req_type     <= next_access.req;
                    neuron_index <= next_access.idx;
                    data_byte    <= next_access.data;
                    in_gap       <= next_gap(in_calm);
                end
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin : check_results
        logic [ACC_W-1:0] want;
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            out_wait  <= 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_acc_values.size() == 0)
                begin
                    $error("acc_value: expected no item, actual %0d", acc_value);
                    error_count++;
                end
                else
                begin
                    want = expected_acc_values.pop_front();
                    if (acc_value !== want)
                    begin
                        $error("acc_value: expected %0d, actual %0d", want, acc_value);
                        error_count++;
                    end
                end
            end
            if (out_wait > 0)
            begin
                out_stall <= 1'b1;
                out_wait  <= out_wait - 1;
            end
            else
            begin
                out_stall <= 1'b0;
                out_wait  <= next_gap(out_calm);
            end
        end
    end

    initial
    begin
        for (int n = 0; n < NEURON_COUNT; n++)
        begin
            weight_shadow[n] = '0;
            acc_shadow[n]    = '0;
        end

        add_access(REQ_READ, 0, 8'h00);
        add_access(REQ_READ, 7, 8'hFF);
        add_access(REQ_BCAST, 3, 8'h00);
        add_access(REQ_BCAST, 5, 8'hFF);
        add_access(REQ_LOAD, 0, 8'hFF);
        add_access(REQ_LOAD, 7, 8'h00);
        add_access(REQ_LOAD, 3, 8'hA5);
        add_access(REQ_LOAD, 4, 8'h5A);
        add_access(REQ_BCAST, 0, 8'hFF);
        add_access(REQ_BCAST, 3, 8'hA5);
        add_access(REQ_BCAST, 7, 8'h00);
        add_access(REQ_READ, 4, 8'h3C);
        add_access(REQ_READ, 7, 8'hC3);
        add_access(REQ_CLEAR, 2, 8'h55);
        add_access(REQ_READ, 3, 8'hAA);
        add_access(REQ_BCAST, 0, 8'h0F);
        add_access(REQ_LOAD, 1, 8'h81);
        add_access(REQ_BCAST, 1, 8'h81);
        add_access(REQ_CLEAR, 6, 8'h00);

        stimulus_count = 0;
        add_saturation_run();
        while (stimulus_count < 600)
        begin
            if ($urandom_range(0, 5) == 0)
            begin
                add_saturation_run();
            end
            else
            begin
                repeat ($urandom_range(10, 40))
                begin
                    add_access(random_req(), $urandom_range(0, 7), $urandom_range(0, 255));
                end
            end
        end

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        while (pending_accesses.size() != 0 || in_valid || expected_acc_values.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (10) @(posedge clk);

        if (error_count == 0)
        begin
            $display("All tests passed");
        end
        else
        begin
            $display("Some tests failed");
        end
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("Some tests failed");
        $finish;
    end

endmodule
